// ----- hw/rtl/msbv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbv_pkg: shared types and constants for the message-waiting body validator
// Grammar phase codes, the header literal and byte class constants.
// ----------------------------------------------------------------------------
package msbv_pkg;

    localparam int HEADER_LEN = 16;
    localparam int LIT_IDX_W  = $clog2(HEADER_LEN);

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_Y     = 8'h79;
    localparam logic [7:0] CHAR_E     = 8'h65;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_O     = 8'h6F;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    typedef enum logic [3:0] {
        PH_LITERAL    = 4'd0,
        PH_PRECOLON   = 4'd1,
        PH_POSTCOLON  = 4'd2,
        PH_SKIPWS     = 4'd3,
        PH_YES_E      = 4'd4,
        PH_YES_S      = 4'd5,
        PH_NO_O       = 4'd6,
        PH_CR1        = 4'd7,
        PH_LF1        = 4'd8,
        PH_LINE_START = 4'd9,
        PH_LINE_MID   = 4'd10,
        PH_LF2        = 4'd11
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [LIT_IDX_W-1:0]   lit_idx;
        logic                   rejected;
    } msbv_state_t;

    localparam msbv_state_t STATE_RESET = '{
        phase:    PH_LITERAL,
        lit_idx:  '0,
        rejected: 1'b0
    };

    // "Messages-Waiting"
    function automatic logic [7:0] header_byte(input logic [LIT_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h4D; // M
            4'd1:    b = 8'h65; // e
            4'd2:    b = 8'h73; // s
            4'd3:    b = 8'h73; // s
            4'd4:    b = 8'h61; // a
            4'd5:    b = 8'h67; // g
            4'd6:    b = 8'h65; // e
            4'd7:    b = 8'h73; // s
            4'd8:    b = 8'h2D; // -
            4'd9:    b = 8'h57; // W
            4'd10:   b = 8'h61; // a
            4'd11:   b = 8'h69; // i
            4'd12:   b = 8'h74; // t
            4'd13:   b = 8'h69; // i
            4'd14:   b = 8'h6E; // n
            4'd15:   b = 8'h67; // g
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage : msbv_pkg
`default_nettype wire

// ----- hw/rtl/msbv_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbv_step: one-byte grammar transition
// Next state and verdict for one input transaction, purely combinational.
// ----------------------------------------------------------------------------
module msbv_step (
    input  msbv_pkg::msbv_state_t cur_state,
    input  logic [7:0]            body_byte,
    input  logic                  last_byte,
    input  logic                  empty_body,
    output msbv_pkg::msbv_state_t nxt_state,
    output logic                  verdict_valid,
    output logic                  verdict_accepted
);
    import msbv_pkg::*;

    logic                 byte_ok;
    phase_t               adv_phase;
    logic [LIT_IDX_W-1:0] adv_idx;
    logic                 is_ws;
    logic                 is_line;
    msbv_state_t          body_state;

    assign is_ws   = (body_byte == CHAR_SP) || (body_byte == CHAR_TAB);
    assign is_line = body_byte inside {CHAR_TAB, [PRINT_LO:PRINT_HI]};

    // Next-phase logic
    always_comb begin
        byte_ok   = 1'b0;
        adv_phase = cur_state.phase;
        adv_idx   = cur_state.lit_idx;
        case (cur_state.phase)
            PH_LITERAL: begin
                if (body_byte == header_byte(cur_state.lit_idx)) begin
                    byte_ok = 1'b1;
                    if (cur_state.lit_idx == LIT_IDX_W'(HEADER_LEN - 1)) begin
                        adv_idx   = '0;
                        adv_phase = PH_PRECOLON;
                    end else begin
                        adv_idx = cur_state.lit_idx + LIT_IDX_W'(1);
                    end
                end
            end
            PH_PRECOLON: begin
                if (is_ws) begin
                    byte_ok = 1'b1;
                end else if (body_byte == CHAR_COLON) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_POSTCOLON;
                end
            end
            PH_POSTCOLON: begin
                if (is_ws) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_SKIPWS;
                end
            end
            PH_SKIPWS: begin
                if (is_ws) begin
                    byte_ok = 1'b1;
                end else if (body_byte == CHAR_Y) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_YES_E;
                end else if (body_byte == CHAR_N) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_NO_O;
                end
            end
            PH_YES_E: begin
                if (body_byte == CHAR_E) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_YES_S;
                end
            end
            PH_YES_S: begin
                if (body_byte == CHAR_S) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_CR1;
                end
            end
            PH_NO_O: begin
                if (body_byte == CHAR_O) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_CR1;
                end
            end
            PH_CR1: begin
                if (body_byte == CHAR_CR) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_LF1;
                end
            end
            PH_LF1, PH_LF2: begin
                if (body_byte == CHAR_LF) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_LINE_START;
                end
            end
            PH_LINE_START, PH_LINE_MID: begin
                if (is_line) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_LINE_MID;
                end else if (body_byte == CHAR_CR) begin
                    byte_ok   = 1'b1;
                    adv_phase = PH_LF2;
                end
            end
            default: begin
                byte_ok = 1'b0;
            end
        endcase
    end

    // Outputs: latched reject freezes the grammar; verdict resets state.
    always_comb begin
        body_state = cur_state;
        if (!cur_state.rejected) begin
            if (byte_ok) begin
                body_state.phase   = adv_phase;
                body_state.lit_idx = adv_idx;
            end else begin
                body_state.rejected = 1'b1;
            end
        end

        verdict_valid = empty_body || last_byte;
        if (empty_body) begin
            verdict_accepted = 1'b1;
        end else begin
            verdict_accepted = !body_state.rejected && (body_state.phase == PH_LINE_START);
        end

        nxt_state = verdict_valid ? STATE_RESET : body_state;
    end

endmodule : msbv_step
`default_nettype wire

// ----- hw/rtl/msbv_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbv_out_stage: result register
// Holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module msbv_out_stage (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  logic push_accepted,
    output logic has_room,
    output logic m_valid,
    input  logic m_ready,
    output logic m_accepted
);
    import msbv_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic accepted_reg;

    // room when empty or when the held result leaves this cycle
    assign has_room   = !valid_reg || m_ready;
    assign valid_next = push || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            accepted_reg <= push_accepted;
        end
    end

    assign m_valid    = valid_reg;
    assign m_accepted = accepted_reg;

endmodule : msbv_out_stage
`default_nettype wire

// ----- hw/rtl/message_summary_body_validator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_summary_body_validator_top: message-waiting body format checker
// Checks a body one byte per transaction and returns a pass/fail verdict.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one body byte per transaction, s_last_byte marks the final
//   byte. A transaction with s_empty_body high stands for a zero-length body
//   and alone yields an accepted verdict; any body in progress is dropped.
//   m_ channel: one verdict (m_accepted) per final byte or empty body;
//   intermediate bytes produce no transaction.
// Latency: the verdict appears on m_valid the cycle after the final byte
//   is taken (one register stage).
// Throughput: one byte per cycle while s_ready is high; the grammar step is
//   a single small transition evaluated between the state and result registers.
// Stall: while a verdict waits with m_ready low, s_ready drops; when the
//   waiting verdict is taken, a new byte is taken in the same cycle.
// Reset: aresetn (synchronous, active low) returns the grammar to the header
//   literal, clears the latched reject and empties the result register.
// After every verdict the grammar state returns to its reset value.
// ----------------------------------------------------------------------------
module message_summary_body_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_body_byte,
    input  logic       s_last_byte,
    input  logic       s_empty_body,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted
);
    import msbv_pkg::*;

    msbv_state_t state_reg;
    msbv_state_t state_next;
    msbv_state_t step_state;
    logic        s_fire;
    logic        verdict_valid;
    logic        verdict_accepted;
    logic        has_room;

    assign s_ready = has_room;
    assign s_fire  = s_valid && s_ready;

    msbv_step u_step (
        .cur_state        (state_reg),
        .body_byte        (s_body_byte),
        .last_byte        (s_last_byte),
        .empty_body       (s_empty_body),
        .nxt_state        (step_state),
        .verdict_valid    (verdict_valid),
        .verdict_accepted (verdict_accepted)
    );

    // grammar state only moves on an accepted transaction
    assign state_next = s_fire ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    msbv_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (s_fire && verdict_valid),
        .push_accepted (verdict_accepted),
        .has_room      (has_room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted)
    );

    // an empty body always passes, with the verdict in the following cycle
    a_empty_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_empty_body |=> m_valid && m_accepted)
        else $error("empty body did not yield an accepted verdict");

    // every verdict restores the reset state
    a_verdict_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_empty_body || s_last_byte) |=>
            state_reg.phase == PH_LITERAL && state_reg.lit_idx == '0 &&
            !state_reg.rejected)
        else $error("grammar state not cleared after verdict");

    // a latched reject can only end in a failing verdict
    a_reject_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_empty_body && s_last_byte && state_reg.rejected |=>
            m_valid && !m_accepted)
        else $error("rejected body reported as accepted");

    // literal index is only in use while matching the header
    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase != PH_LITERAL |-> state_reg.lit_idx == '0)
        else $error("literal index nonzero outside header phase");

endmodule : message_summary_body_validator_top
`default_nettype wire

// ----- tb/tb_message_summary_body_validator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_message_summary_body_validator_top: self-checking bench for the
// message-waiting body validator.
// Bodies go in one byte per transaction. A grammar tracker inside the bench
// computes the verdict each body should get. Every verdict the block returns
// is checked in order against that tracker. Traffic covers directed corner
// cases, well-formed and damaged bodies, random noise and a long receiver
// hold-off, with random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_message_summary_body_validator_top;
    import msbv_pkg::*;

    localparam int          TIMEOUT_NS   = 1_000_000;
    localparam int          ITEM_TARGET  = 700;
    localparam int          MIN_VERDICTS = 48;
    localparam int          HOLD_CYCLES  = 120;
    // verdict is registered once, so this drain covers the tail
    localparam int          DRAIN_CYCLES = 4;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [8*HEADER_LEN-1:0] HDR_TEXT = "Messages-Waiting";

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_body_byte;
    logic       s_last_byte;
    logic       s_empty_body;
    logic       m_valid;
    logic       m_ready;
    logic       m_accepted;

    message_summary_body_validator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_body_byte (s_body_byte),
        .s_last_byte (s_last_byte),
        .s_empty_body(s_empty_body),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accepted  (m_accepted)
    );

    // ------------------------------------------------------------------------
    // Grammar tracker: the bench's own view of where each body stands.
    // ------------------------------------------------------------------------
    phase_t               gram_phase    = PH_LITERAL;
    logic [LIT_IDX_W-1:0] gram_lit      = '0;
    logic                 gram_rejected = 1'b0;

    logic verdict_q[$];     // verdicts still owed by the block, oldest first
    logic [7:0] body_q[$];  // bytes of the body being built for sending

    int items_sent    = 0;
    int verdicts_seen = 0;
    int fail_cnt      = 0;
    int burst_left    = 0;
    bit hold_req      = 1'b0;

    function automatic logic [7:0] hdr_char(input int idx);
        return HDR_TEXT[8*(HEADER_LEN-1-idx) +: 8];
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SP) || (b == CHAR_TAB);
    endfunction

    function automatic void restart_grammar();
        gram_phase    = PH_LITERAL;
        gram_lit      = '0;
        gram_rejected = 1'b0;
    endfunction

    // Advance the tracker by one transaction. Returns 1 when the transaction
    // closes a body; the verdict comes back through 'verdict'.
    function automatic logic predict_verdict(input logic [7:0] b, input logic last,
                                             input logic empty, output logic verdict);
        logic ok;
        verdict = 1'b0;
        // empty body: instant accept, any body in flight is dropped
        if (empty) begin
            restart_grammar();
            verdict = 1'b1;
            return 1'b1;
        end
        // once rejected, bytes are no longer looked at
        if (!gram_rejected) begin
            ok = 1'b1;
            case (gram_phase)
                PH_LITERAL: begin
                    if (b != hdr_char(int'(gram_lit))) begin
                        ok = 1'b0;
                    end else if (gram_lit == LIT_IDX_W'(HEADER_LEN - 1)) begin
                        gram_lit   = '0;
                        gram_phase = PH_PRECOLON;
                    end else begin
                        gram_lit = gram_lit + LIT_IDX_W'(1);
                    end
                end
                PH_PRECOLON: begin
                    if (b == CHAR_COLON) gram_phase = PH_POSTCOLON;
                    else if (!is_blank(b)) ok = 1'b0;
                end
                PH_POSTCOLON: begin
                    if (is_blank(b)) gram_phase = PH_SKIPWS;
                    else ok = 1'b0;
                end
                PH_SKIPWS: begin
                    if (b == CHAR_Y) gram_phase = PH_YES_E;
                    else if (b == CHAR_N) gram_phase = PH_NO_O;
                    else if (!is_blank(b)) ok = 1'b0;
                end
                PH_YES_E: begin
                    if (b == CHAR_E) gram_phase = PH_YES_S;
                    else ok = 1'b0;
                end
                PH_YES_S: begin
                    if (b == CHAR_S) gram_phase = PH_CR1;
                    else ok = 1'b0;
                end
                PH_NO_O: begin
                    if (b == CHAR_O) gram_phase = PH_CR1;
                    else ok = 1'b0;
                end
                PH_CR1: begin
                    if (b == CHAR_CR) gram_phase = PH_LF1;
                    else ok = 1'b0;
                end
                PH_LF1, PH_LF2: begin
                    if (b == CHAR_LF) gram_phase = PH_LINE_START;
                    else ok = 1'b0;
                end
                PH_LINE_START, PH_LINE_MID: begin
                    if (b == CHAR_TAB || (b >= PRINT_LO && b <= PRINT_HI))
                        gram_phase = PH_LINE_MID;
                    else if (b == CHAR_CR)
                        gram_phase = PH_LF2;
                    else
                        ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok) gram_rejected = 1'b1;
        end
        if (!last) return 1'b0;
        // accept only when clean and sitting right after a closing CR LF
        verdict = !gram_rejected && (gram_phase == PH_LINE_START);
        restart_grammar();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted input transaction and checks every
    // accepted verdict. Sampling happens at the edge, before the NBA updates
    // of that edge land, so it sees exactly what the block sees.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        logic owes, v, want;
        if (aresetn) begin
            // check first: a verdict leaving now belongs to an older body
            if (m_valid && m_ready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("[%0t] unexpected verdict: accepted=%0b", $realtime,
                                 m_accepted);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_accepted !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display("[%0t] verdict %0d mismatch: expected=%0b actual=%0b",
                                     $realtime, verdicts_seen, want, m_accepted);
                    end
                end
            end
            if (s_valid && s_ready) begin
                owes = predict_verdict(s_body_byte, s_last_byte, s_empty_body, v);
                if (owes) verdict_q.push_back(v);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: cycles through ready patterns; a hold-off request holds ready
    // low so the block backs up into the input side.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int span;
        int hold_cnt;
        int tick;
        m_ready  <= 1'b0;
        mode     = 0;
        span     = 0;
        hold_cnt = 0;
        tick     = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    0:       m_ready <= 1'b1;                          // wide open
                    1:       m_ready <= ($urandom_range(0, 9) < 7);    // random
                    2:       m_ready <= ((tick % 5) >= 2);             // short stalls
                    default: m_ready <= ((tick % 16) < 4);             // long stalls
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One input transaction. Called at a rising edge; returns at the edge
    // where the transaction is taken. Bursts of random length are separated
    // by random gaps.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_body_byte  <= b;
        s_last_byte  <= last;
        s_empty_body <= empty;
        @(posedge aclk iff s_ready);
        items_sent++;
    endtask

    // Send body_q as one body, final byte flagged.
    task automatic send_body();
        int i;
        for (i = 0; i < body_q.size(); i++)
            send_byte(body_q[i], i == body_q.size() - 1, 1'b0);
    endtask

    // Empty-body transaction; byte and last flag are don't-care, so randomize.
    task automatic send_empty();
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // Sender pause: stop offering and let every owed verdict come back.
    task automatic wait_for_verdicts();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CHAR_SP : CHAR_TAB;
    endfunction

    // Build a well-formed body in body_q with random spacing, status and lines.
    function automatic void build_wellformed(input int max_lines, input int max_len);
        int i;
        int j;
        int n;
        int len;
        body_q.delete();
        for (i = 0; i < HEADER_LEN; i++) body_q.push_back(hdr_char(i));
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) body_q.push_back(blank_char());
        body_q.push_back(CHAR_COLON);
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) body_q.push_back(blank_char());
        if ($urandom_range(0, 1)) begin
            body_q.push_back(CHAR_Y);
            body_q.push_back(CHAR_E);
            body_q.push_back(CHAR_S);
        end else begin
            body_q.push_back(CHAR_N);
            body_q.push_back(CHAR_O);
        end
        body_q.push_back(CHAR_CR);
        body_q.push_back(CHAR_LF);
        n = $urandom_range(0, max_lines);
        for (i = 0; i < n; i++) begin
            len = $urandom_range(0, max_len);
            for (j = 0; j < len; j++)
                body_q.push_back(($urandom_range(0, 7) == 0) ? CHAR_TAB
                                 : 8'($urandom_range(PRINT_LO, PRINT_HI)));
            body_q.push_back(CHAR_CR);
            body_q.push_back(CHAR_LF);
        end
    endfunction

    // Damage body_q in one random way; result is never empty.
    function automatic void damage_body();
        int pos;
        int n;
        int i;
        pos = $urandom_range(0, body_q.size() - 1);
        case ($urandom_range(0, 4))
            0: body_q[pos] = 8'($urandom_range(0, 255));          // overwrite
            1: while (body_q.size() > pos + 1) void'(body_q.pop_back()); // cut short
            2: body_q.insert(pos, 8'($urandom_range(0, 255)));    // extra byte
            3: if (body_q.size() > 1) body_q.delete(pos);         // drop a byte
            default: begin                                        // unterminated tail
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    body_q.push_back(8'($urandom_range(PRINT_LO, 255)));
            end
        endcase
    endfunction

    // Short runs of arbitrary bytes, mostly out of grammar.
    function automatic void build_noise();
        int n;
        int i;
        body_q.delete();
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Directed corners: empty bodies, one-byte bodies, abandoned body,
    // bytes after a latched reject, top-range bytes.
    task automatic test_directed();
        send_byte(8'hFF, 1'b1, 1'b1);       // empty body, junk byte, last set
        send_byte(8'h00, 1'b0, 1'b1);       // empty body, last clear
        send_byte(8'hFF, 1'b1, 1'b0);       // lone top-range byte
        send_byte(hdr_char(0), 1'b1, 1'b0); // body ends inside the literal
        send_byte(hdr_char(0), 1'b0, 1'b0); // partial body ...
        send_byte(hdr_char(1), 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);       // ... abandoned by an empty body
        send_byte(8'h3F, 1'b0, 1'b0);       // reject on first byte
        send_byte(8'h80, 1'b0, 1'b0);       // further bytes ignored
        send_byte(8'h7F, 1'b1, 1'b0);
        wait_for_verdicts();
    endtask

    // Well-formed bodies, mostly short, a few with long lines.
    task automatic test_wellformed();
        int k;
        for (k = 0; k < 8; k++) begin
            if (k < 6) build_wellformed(2, 6);
            else build_wellformed(5, 40);
            send_body();
        end
    endtask

    // Bodies with one defect each.
    task automatic test_damaged();
        int k;
        for (k = 0; k < 8; k++) begin
            build_wellformed(2, 6);
            damage_body();
            send_body();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing
    // verdict-producing transactions; the block must stall its input.
    task automatic test_backpressure();
        int k;
        burst_left = 64;
        hold_req   = 1'b1;
        for (k = 0; k < 24; k++) begin
            if (k % 3 == 0) send_empty();
            else send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        build_wellformed(1, 4);
        send_body();
        wait_for_verdicts();
    endtask

    // Random mix until enough traffic and verdicts have gone through.
    task automatic test_random_mix();
        int pick;
        int keep;
        while (items_sent < ITEM_TARGET || verdicts_seen < MIN_VERDICTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                build_wellformed(2, 8);
                send_body();
            end else if (pick < 70) begin
                build_wellformed(2, 8);
                damage_body();
                send_body();
            end else if (pick < 80) begin
                build_noise();
                send_body();
            end else if (pick < 90) begin
                send_empty();
            end else begin
                // partial body dropped by an empty body
                build_wellformed(1, 4);
                keep = $urandom_range(1, body_q.size() - 1);
                while (body_q.size() > keep) void'(body_q.pop_back());
                foreach (body_q[i]) send_byte(body_q[i], 1'b0, 1'b0);
                send_empty();
            end
            if ($urandom_range(0, 19) == 0) wait_for_verdicts();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        s_valid      <= 1'b0;
        s_body_byte  <= 8'h00;
        s_last_byte  <= 1'b0;
        s_empty_body <= 1'b0;
        aresetn      <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_wellformed();
        test_damaged();
        test_backpressure();
        test_random_mix();

        wait_for_verdicts();
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
